FILE: src/dae_pkg.sv
// Shared constants, types and codes for the decimal ASCII emitter.
package dae_pkg;

   // Input value and output character widths
   localparam int VALUE_WIDTH = 32;
   localparam int CHAR_WIDTH  = 8;

   // One BCD digit per cell; ten cells cover every 32-bit value
   localparam int DIGIT_WIDTH = 4;
   localparam int NUM_CELLS   = 10;

   // Largest number of digit characters sent per word
   localparam int MAX_DIGITS  = 10;

   // Counter widths
   localparam int BIT_COUNT_WIDTH = $clog2(VALUE_WIDTH);
   localparam int REMAIN_WIDTH    = $clog2(NUM_CELLS + 1);

   // Character codes
   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] TERMINATOR = 8'h00;

   // What every digit cell does in a cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_CONVERT,
      CELL_SHIFT
   } cell_mode_type;

   // Control handed from the sequencer to the digit chain
   typedef struct packed {
      cell_mode_type mode;
      logic          load;
   } chain_ctrl_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT,
      ST_TERM
   } state_type;

endpackage

FILE: src/dae_cell.sv
// One BCD digit cell: add-3 and shift during conversion, digit shift during output.
module dae_cell (
   input  logic                         clock,
   input  dae_pkg::cell_mode_type       mode,
   input  logic                         carry_in,
   output logic                         carry_out,
   input  logic [dae_pkg::DIGIT_WIDTH-1:0] digit_in,
   output logic [dae_pkg::DIGIT_WIDTH-1:0] digit_out
);
   import dae_pkg::*;

   logic [DIGIT_WIDTH-1:0] digit_ff;
   logic [DIGIT_WIDTH-1:0] digit_ff_in;
   logic [DIGIT_WIDTH-1:0] adjusted;

   // Add 3 when the digit is five or more, so the shift carries correctly
   always_comb begin
      if (digit_ff >= DIGIT_WIDTH'(5)) begin
         adjusted = digit_ff + DIGIT_WIDTH'(3);
      end else begin
         adjusted = digit_ff;
      end
   end

   assign carry_out = adjusted[DIGIT_WIDTH-1];

   // Next digit by mode
   always_comb begin
      unique case (mode)
         CELL_CLEAR:   digit_ff_in = '0;
         CELL_CONVERT: digit_ff_in = {adjusted[DIGIT_WIDTH-2:0], carry_in};
         CELL_SHIFT:   digit_ff_in = digit_in;
         default:      digit_ff_in = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_ff_in;
   end

   assign digit_out = digit_ff;

endmodule

FILE: src/dae_chain.sv
// Row of BCD digit cells fed by the binary shift register.
module dae_chain (
   input  logic                            clock,
   input  logic                            reset,
   input  dae_pkg::chain_ctrl_type         ctrl,
   input  logic [dae_pkg::VALUE_WIDTH-1:0] value,
   output logic [dae_pkg::DIGIT_WIDTH-1:0] top_digit
);
   import dae_pkg::*;

   logic [VALUE_WIDTH-1:0] bin_ff;
   logic [VALUE_WIDTH-1:0] bin_in;
   logic [NUM_CELLS:0]     carry;
   logic [DIGIT_WIDTH-1:0] digits [NUM_CELLS];

   // Binary word: loaded on accept, shifted out msb first into the chain
   always_comb begin
      if (ctrl.load) begin
         bin_in = value;
      end else if (ctrl.mode == CELL_CONVERT) begin
         bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
      end else begin
         bin_in = bin_ff;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
   end

   assign carry[0] = bin_ff[VALUE_WIDTH-1];

   // Cell 0 holds the least significant digit
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      logic [DIGIT_WIDTH-1:0] shift_src;
      if (i == 0) begin : g_first
         assign shift_src = '0;
      end else begin : g_rest
         assign shift_src = digits[i-1];
      end
      dae_cell u_cell (
         .clock     (clock),
         .mode      (ctrl.mode),
         .carry_in  (carry[i]),
         .carry_out (carry[i+1]),
         .digit_in  (shift_src),
         .digit_out (digits[i])
      );
   end

   assign top_digit = digits[NUM_CELLS-1];

   // A 32-bit value fits in the chain: nothing ever leaves the top cell
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      ctrl.mode == CELL_CONVERT |-> !carry[NUM_CELLS])
      else $error("digit chain overflow");

   // Load always clears the cells in the same cycle
   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |-> ctrl.mode == CELL_CLEAR)
      else $error("load without cell clear");

   // The top digit stays in BCD range while shifting out
   a_bcd_top: assert property (@(posedge clock) disable iff (reset)
      ctrl.mode == CELL_SHIFT |-> top_digit <= DIGIT_WIDTH'(9))
      else $error("top digit out of BCD range");

endmodule

FILE: src/decimal_ascii_emitter.sv
// Top level: sequencer, digit chain and output word register.
//
// Usage
//   req_* takes one word: an unsigned 32-bit value in req_tdata.
//   rsp_* returns its decimal digits as ASCII, most significant first, with
//   no leading zeros (zero gives a single '0'), then a zero byte with
//   rsp_tlast high. Only the ten least significant digits are ever sent.
// Timing
//   The word is loaded, then shifted bit by bit with add-3 through the
//   digit cells; leading zero digits are skipped (up to 9) before output
//   starts, then one character per cycle while the receiver takes them,
//   and the terminator. Skipped plus sent digits always make ten.
//   Output shifts the row of cells up one digit per character taken.
//   req_tready is high only while no word is in progress; the next word
//   is taken while the terminator still waits in the output register.
// Reset
//   Synchronous, active high: returns to idle and drops rsp_tvalid.
// Stall
//   A low rsp_tready holds the output word and pauses the digit shift; no
//   character is lost or repeated.
module decimal_ascii_emitter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dae_pkg::VALUE_WIDTH-1:0] req_tdata,  // [31:0] value
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [dae_pkg::CHAR_WIDTH-1:0]  rsp_tdata,  // [7:0] char_out
   output logic                            rsp_tlast
);
   import dae_pkg::*;

   state_type                state_ff, state_in;
   logic [BIT_COUNT_WIDTH-1:0] bit_cnt_ff, bit_cnt_in;
   logic [REMAIN_WIDTH-1:0]  remain_ff, remain_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]    rsp_data_ff, rsp_data_in;
   logic                     rsp_last_ff, rsp_last_in;
   chain_ctrl_type           chain_ctrl;
   logic [DIGIT_WIDTH-1:0]   top_digit;
   logic                     slot_free;

   dae_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (chain_ctrl),
      .value     (req_tdata),
      .top_digit (top_digit)
   );

   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Next state, counters, chain control and output word
   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      chain_ctrl   = '{mode: CELL_HOLD, load: 1'b0};
      req_tready   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               chain_ctrl = '{mode: CELL_CLEAR, load: 1'b1};
               bit_cnt_in = '0;
               remain_in  = REMAIN_WIDTH'(NUM_CELLS);
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            chain_ctrl.mode = CELL_CONVERT;
            bit_cnt_in      = bit_cnt_ff + BIT_COUNT_WIDTH'(1);
            if (bit_cnt_ff == BIT_COUNT_WIDTH'(VALUE_WIDTH - 1)) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop digits above the limit and leading zeros, keep at least one
            if (remain_ff > REMAIN_WIDTH'(MAX_DIGITS) ||
                (top_digit == '0 && remain_ff > REMAIN_WIDTH'(1))) begin
               chain_ctrl.mode = CELL_SHIFT;
               remain_in       = remain_ff - REMAIN_WIDTH'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_data_in     = ASCII_ZERO + {{(CHAR_WIDTH-DIGIT_WIDTH){1'b0}}, top_digit};
               rsp_last_in     = 1'b0;
               chain_ctrl.mode = CELL_SHIFT;
               remain_in       = remain_ff - REMAIN_WIDTH'(1);
               if (remain_ff == REMAIN_WIDTH'(1)) begin
                  state_in = ST_TERM;
               end
            end
         end
         ST_TERM: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = TERMINATOR;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Counters and output word payload
   always_ff @(posedge clock) begin
      bit_cnt_ff  <= bit_cnt_in;
      remain_ff   <= remain_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // A digit word is always an ASCII digit
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata >= ASCII_ZERO && rsp_tdata <= 8'h39)
      else $error("non-digit character sent");

   // The last word of a value is the zero byte
   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == TERMINATOR)
      else $error("terminator is not zero");

   // Emitting never runs with no digits left
   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> remain_ff != '0 && remain_ff <= REMAIN_WIDTH'(MAX_DIGITS))
      else $error("digit count out of range while emitting");

   // Sending the terminator completes the word and frees the input
   a_term_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TERM && slot_free |=> rsp_tvalid && rsp_tlast && req_tready)
      else $error("terminator not sent");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the decimal ASCII emitter: directed, streaming and random words.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dae_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;
   localparam int DRAIN_CYCLES   = 60;
   localparam int MAX_REPORTS    = 10;

   // One expected output word
   typedef struct packed {
      logic [CHAR_WIDTH-1:0] char_code;
      logic                  is_last;
   } text_word_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [VALUE_WIDTH-1:0] req_tdata;   // [31:0] value
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [CHAR_WIDTH-1:0]  rsp_tdata;   // [7:0] char_out
   logic                   rsp_tlast;

   text_word_type expected_text[$];
   text_word_type oldest_text;
   int         mismatch_count;
   int         quiet_cycles;
   bit         send_idle;
   bit         take_idle;
   bit         long_hold_request;

   decimal_ascii_emitter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Expected characters for one value: digits MS first, then the terminator
   function automatic void predict_text(input logic [VALUE_WIDTH-1:0] value);
      logic [DIGIT_WIDTH-1:0] digit [NUM_CELLS];
      logic [VALUE_WIDTH-1:0] rest;
      int                     count;
      int                     keep;
      rest  = value;
      count = 0;
      do begin
         digit[count] = DIGIT_WIDTH'(rest % 10);
         rest         = rest / 10;
         count++;
      end while (rest != 0 && count < NUM_CELLS);
      keep = (count > MAX_DIGITS) ? MAX_DIGITS : count;
      for (int k = keep - 1; k >= 0; k--)
         expected_text.push_back('{ASCII_ZERO + CHAR_WIDTH'(digit[k]), 1'b0});
      expected_text.push_back('{TERMINATOR, 1'b1});
   endfunction

   // Random value, mostly spread evenly over the number of digits
   function automatic logic [VALUE_WIDTH-1:0] random_value();
      int unsigned       digits;
      longint unsigned   lo;
      longint unsigned   hi;
      longint unsigned   wide;
      if ($urandom_range(0, 4) == 0)
         return $urandom();
      digits = $urandom_range(1, 10);
      lo     = 1;
      repeat (digits - 1) lo = lo * 10;
      hi     = lo * 10 - 1;
      if (hi > 64'hFFFF_FFFF)
         hi = 64'hFFFF_FFFF;
      wide   = {$urandom(), $urandom()};
      return VALUE_WIDTH'(lo + wide % (hi - lo + 1));
   endfunction

   // Offer one word after an optional gap; returns at the accepting edge
   task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
      int gap;
      gap = send_idle ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      predict_text(value);
   endtask

   // Receiver: random stalls per word, plus a long hold on request
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         stall = take_idle ? $urandom_range(0, 8) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Compare each accepted character with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_text.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected word: char 0x%02h last %0b", rsp_tdata, rsp_tlast);
         end else begin
            oldest_text = expected_text.pop_front();
            if (rsp_tdata !== oldest_text.char_code || rsp_tlast !== oldest_text.is_last) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: expected char 0x%02h last %0b, got char 0x%02h last %0b",
                           oldest_text.char_code, oldest_text.is_last, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Field extremes, digit count boundaries, zero and full-scale values
   task automatic test_directed();
      logic [VALUE_WIDTH-1:0] values [] = '{
         32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd4294967295, 32'd4294967294,
         32'd1000000000, 32'd999999999, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555,
         32'hAAAA_AAAA, 32'd123456789, 32'd1000000001, 32'd4000000000, 32'd100000,
         32'd909090909, 32'd10000000};
      send_idle = 1'b1;
      take_idle = 1'b1;
      foreach (values[i]) send_value(values[i]);
   endtask

   // Words streamed with no gaps on either side
   task automatic test_back_to_back();
      send_idle = 1'b0;
      take_idle = 1'b0;
      repeat (40) send_value(random_value());
   endtask

   // Receiver holds off for a long stretch while words keep coming
   task automatic test_output_hold();
      send_idle = 1'b0;
      take_idle = 1'b1;
      long_hold_request = 1'b1;
      repeat (10) send_value(random_value());
   endtask

   // Random words with idling switched on and off in stretches
   task automatic test_random();
      for (int n = 0; n < 390; n++) begin
         if (n % 60 == 0) begin
            send_idle = ($urandom_range(0, 3) != 0);
            take_idle = ($urandom_range(0, 3) != 0);
         end
         send_value(random_value());
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_tvalid     <= 1'b0;
      req_tdata      <= '0;
      mismatch_count = 0;
      send_idle      = 1'b1;
      take_idle      = 1'b1;
      long_hold_request = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_back_to_back();
      test_output_hold();
      test_random();

      // Drain, then allow stray words time to show up
      req_tvalid <= 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_text.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
